/* rtl/pfp_pkg.sv */
// Shared types, codes and datapath widths of the polyline Frenet projection block.
`timescale 1ns / 1ps
`default_nettype none

package pfp_pkg;

  // Command codes of an input word.
  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  // Status codes of a result word.
  localparam logic [2:0] STAT_OK   = 3'd0;
  localparam logic [2:0] STAT_FEW  = 3'd1;
  localparam logic [2:0] STAT_FULL = 3'd2;
  localparam logic [2:0] STAT_DEC  = 3'd3;
  localparam logic [2:0] STAT_ARC0 = 3'd4;

  // Field and datapath widths.
  localparam int unsigned COORD_W = 32;
  localparam int unsigned ARC_W   = 31;
  localparam int unsigned DIFF_W  = 33;
  localparam int unsigned SEGL_W  = 33;
  localparam int unsigned MUL_AW  = 68;
  localparam int unsigned MUL_BW  = 34;
  localparam int unsigned MUL_PW  = MUL_AW + MUL_BW;
  localparam int unsigned DIV_NW  = 100;
  localparam int unsigned DIV_DW  = 68;
  localparam int unsigned SQ_W    = 68;
  localparam int unsigned ROOT_W  = SQ_W / 2;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic        [ARC_W-1:0]   arc;
  } point_t;

  typedef struct packed {
    logic pt_we;
    logic sl_we;
  } mem_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ACHK, S_AWR, S_RD0, S_RD1, S_LD, S_CHK, S_MGO,
    S_MWT, S_CLS, S_DGO, S_DWT, S_QGO, S_QWT, S_CMP, S_OUT
  } state_e;

  typedef enum logic [3:0] {
    MOP_DXEX, MOP_DYEY, MOP_EXDY, MOP_EYDX, MOP_EXEX, MOP_EYEY,
    MOP_DDX, MOP_DDY, MOP_PROD
  } mop_e;

  typedef enum logic {
    DOP_LAT,
    DOP_STEP
  } dop_e;

endpackage

`default_nettype wire

/* rtl/pfp_mem.sv */
// Point store and segment length store, one write and one registered read each.
`timescale 1ns / 1ps
`default_nettype none

module pfp_mem #(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                          clk_i,
  input  wire pfp_pkg::mem_ctl_t             ctl_i,
  input  wire logic [AW-1:0]                 pt_waddr_i,
  input  wire pfp_pkg::point_t               pt_wdata_i,
  input  wire logic [AW-1:0]                 sl_waddr_i,
  input  wire logic [pfp_pkg::SEGL_W-1:0]    sl_wdata_i,
  input  wire logic [AW-1:0]                 raddr_i,
  output pfp_pkg::point_t                    pt_rdata_o,
  output logic [pfp_pkg::SEGL_W-1:0]         sl_rdata_o
);

  pfp_pkg::point_t             pt_mem [DEPTH];
  logic [pfp_pkg::SEGL_W-1:0]  sl_mem [DEPTH];
  pfp_pkg::point_t             pt_rdata_q;
  logic [pfp_pkg::SEGL_W-1:0]  sl_rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.pt_we) begin
      pt_mem[pt_waddr_i] <= pt_wdata_i;
    end
    pt_rdata_q <= pt_mem[raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.sl_we) begin
      sl_mem[sl_waddr_i] <= sl_wdata_i;
    end
    sl_rdata_q <= sl_mem[raddr_i];
  end

  assign pt_rdata_o = pt_rdata_q;
  assign sl_rdata_o = sl_rdata_q;

endmodule

`default_nettype wire

/* rtl/pfp_mul.sv */
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module pfp_mul (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [pfp_pkg::MUL_AW-1:0]    a_i,
  input  wire logic [pfp_pkg::MUL_BW-1:0]    b_i,
  output logic                               done_o,
  output logic [pfp_pkg::MUL_PW-1:0]         p_o
);

  localparam int unsigned CNT_W = $clog2(pfp_pkg::MUL_BW);

  logic                          busy_q;
  logic                          done_q;
  logic [CNT_W-1:0]              cnt_q;
  logic [pfp_pkg::MUL_PW-1:0]    a_q;
  logic [pfp_pkg::MUL_PW-1:0]    acc_q;
  logic [pfp_pkg::MUL_BW-1:0]    b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(pfp_pkg::MUL_BW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= pfp_pkg::MUL_PW'(a_i);
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= a_q << 1;
      b_q <= b_q >> 1;
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

`default_nettype wire

/* rtl/pfp_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module pfp_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [pfp_pkg::DIV_NW-1:0]    num_i,
  input  wire logic [pfp_pkg::DIV_DW-1:0]    den_i,
  output logic                               done_o,
  output logic [pfp_pkg::DIV_NW-1:0]         quo_o
);

  localparam int unsigned CNT_W = $clog2(pfp_pkg::DIV_NW);

  logic                          busy_q;
  logic                          done_q;
  logic [CNT_W-1:0]              cnt_q;
  logic [pfp_pkg::DIV_NW-1:0]    num_q;
  logic [pfp_pkg::DIV_NW-1:0]    quo_q;
  logic [pfp_pkg::DIV_DW-1:0]    den_q;
  logic [pfp_pkg::DIV_DW-1:0]    rem_q;
  logic [pfp_pkg::DIV_DW:0]      trial;
  logic [pfp_pkg::DIV_DW:0]      diff;
  logic                          fits;

  assign trial = {rem_q, num_q[pfp_pkg::DIV_NW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(pfp_pkg::DIV_NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= num_q << 1;
      rem_q <= fits ? diff[pfp_pkg::DIV_DW-1:0] : trial[pfp_pkg::DIV_DW-1:0];
      quo_q <= {quo_q[pfp_pkg::DIV_NW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

/* rtl/pfp_sqrt.sv */
// Digit-recurrence integer square root, one root bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module pfp_sqrt (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [pfp_pkg::SQ_W-1:0]      rad_i,
  output logic                               done_o,
  output logic [pfp_pkg::ROOT_W-1:0]         root_o
);

  localparam int unsigned CNT_W = $clog2(pfp_pkg::ROOT_W);
  localparam int unsigned RW    = pfp_pkg::ROOT_W + 2;

  logic                          busy_q;
  logic                          done_q;
  logic [CNT_W-1:0]              cnt_q;
  logic [pfp_pkg::SQ_W-1:0]      rad_q;
  logic [pfp_pkg::ROOT_W-1:0]    root_q;
  logic [RW-1:0]                 rem_q;
  logic [RW+1:0]                 rn;
  logic [RW+1:0]                 tr;
  logic                          fits;

  assign rn   = {rem_q, rad_q[pfp_pkg::SQ_W-1 -: 2]};
  assign tr   = (RW + 2)'({root_q, 2'b01});
  assign fits = rn >= tr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(pfp_pkg::ROOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      root_q <= '0;
      rem_q  <= '0;
    end else if (busy_q) begin
      rad_q  <= rad_q << 2;
      rem_q  <= fits ? RW'(rn - tr) : rn[RW-1:0];
      root_q <= {root_q[pfp_pkg::ROOT_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

/* rtl/polyline_frenet_projection.sv */
// Top level: command sequencer, segment walk and result register of the projection block.
`timescale 1ns / 1ps
`default_nettype none

// The block holds a polyline of up to MAX_POINTS points (x, y, arc) in an on-chip
// point memory, plus the floor length of each segment in a second memory. A clear
// word empties the path, an append word adds one point (first arc must be zero, arcs
// must not decrease), and a query word projects (x, y) onto every stored segment and
// returns the (s, l) of the segment with the smallest |l|, earliest one on a tie.
// Exactly one result word comes back per input word. One word is worked on at a
// time: in_stall_o is high from acceptance until the result is handed to the output
// register, which may still hold the previous word's result while the next word
// starts. Every product, quotient and root goes through a shared bit-serial unit
// (34 multiplier steps, 100 divider steps, 34 root steps). Clear and other words that
// neither append nor query go straight to the result, the first append writes its point
// at once, and a later append checks the arc and, if it holds, squares the step from
// the last point and stores its root as the segment length. A query walks the segments:
// a zero-length one takes the root of its squared distance to the start, a clamp to an end
// point takes the dot, cross and length products and then the root for that end point,
// and the projecting path divides for l, then multiplies and divides for s. Memory accesses never
// overlap: the sequencer reads, computes and writes back in turn, so no forwarding
// is needed. Neither memory is cleared; only entries below the point count are read.

module polyline_frenet_projection #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [1:0]          command_i,
  input  wire logic signed [31:0]  x_coord_i,
  input  wire logic signed [31:0]  y_coord_i,
  input  wire logic [30:0]         arc_pos_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic signed [31:0]       out_s_o,
  output logic signed [31:0]       out_l_o,
  output logic [2:0]               status_o
);

  localparam int unsigned AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW    = $clog2(MAX_POINTS + 1);
  localparam int unsigned DW    = pfp_pkg::DIFF_W;
  localparam int unsigned DOT_W = 69;
  localparam int unsigned MAG_W = 41;
  localparam int unsigned SO_W  = 42;
  localparam logic [MAG_W-1:0] STEP_CAP = MAG_W'(1) << 40;

  function automatic logic [DW-1:0] mag33(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] n;
    n = -v;
    return v[DW-1] ? n : v;
  endfunction

  function automatic logic [MAG_W-1:0] cap40(input logic [pfp_pkg::DIV_NW-1:0] q);
    logic over;
    over = (|q[pfp_pkg::DIV_NW-1:MAG_W]) || (q[MAG_W-1] && (|q[MAG_W-2:0]));
    return over ? STEP_CAP : q[MAG_W-1:0];
  endfunction

  function automatic logic [31:0] sat32(input logic signed [SO_W-1:0] v);
    logic in_range;
    in_range = (v[SO_W-1:31] == {(SO_W - 31){v[SO_W-1]}});
    if (in_range) begin
      return v[31:0];
    end
    return v[SO_W-1] ? 32'h8000_0000 : 32'h7fff_ffff;
  endfunction

  // control state
  pfp_pkg::state_e       state_q, state_d;
  logic [CW-1:0]         count_q;
  logic                  out_valid_q;

  // word and segment registers
  pfp_pkg::cmd_e         cmd_q;
  logic signed [31:0]    x_q, y_q;
  logic [30:0]           arc_q;
  logic [2:0]            status_q;
  logic                  app_q;
  logic [AW-1:0]         k_q;
  logic signed [31:0]    x0_q, y0_q, x1_q, y1_q;
  logic [30:0]           s0_q, s1_q;
  logic [pfp_pkg::SEGL_W-1:0] sl_q;
  logic signed [DW-1:0]  ex_q, ey_q, dx_q, dy_q, vx_q, vy_q;
  logic signed [DOT_W-1:0] dot_q, cross_q;
  logic [pfp_pkg::MUL_AW-1:0] n2_q, rad_q;
  logic [pfp_pkg::DIV_NW-1:0] prod_q;
  logic [MAG_W-1:0]      mag_q, best_q;
  logic                  neg_q, have_q;
  logic signed [SO_W-1:0] sseg_q, res_s_q, res_l_q;
  pfp_pkg::mop_e         mop_q;
  pfp_pkg::dop_e         dop_q;
  logic [31:0]           out_s_q, out_l_q;
  logic [2:0]            out_status_q;

  // memory and unit signals
  pfp_pkg::mem_ctl_t     mem_ctl;
  logic [AW-1:0]         raddr, pt_waddr, sl_waddr;
  pfp_pkg::point_t       pt_wdata, rd_pt;
  logic [pfp_pkg::SEGL_W-1:0] rd_sl;
  logic                  mul_start, mul_done, div_start, div_done, sq_start, sq_done;
  logic [pfp_pkg::MUL_AW-1:0] mul_a;
  logic [pfp_pkg::MUL_BW-1:0] mul_b;
  logic [pfp_pkg::MUL_PW-1:0] mul_p;
  logic                  mul_neg;
  logic [DW-1:0]         ma33, mb33;
  logic [pfp_pkg::DIV_NW-1:0] div_num, div_quo;
  logic [pfp_pkg::DIV_DW-1:0] div_den;
  logic [pfp_pkg::ROOT_W-1:0] sq_root;

  // decode
  logic                  in_fire, full, few, k_first, k_last, arc_bad, degen;
  logic                  dot_neg, before_start, past_end, out_free;
  logic [CW-1:0]         last_w, cm1_w;
  logic signed [DOT_W-1:0] term, term_pos, dot_abs, cross_abs;
  logic [30:0]           ds;
  logic [MAG_W-1:0]      div_cap;
  logic signed [SO_W-1:0] s0_ext, step_ext;
  logic signed [SO_W-1:0] mag_ext;

  assign in_fire  = in_valid_i && (state_q == pfp_pkg::S_IDLE);
  assign full     = count_q == CW'(MAX_POINTS);
  assign few      = count_q < CW'(2);
  assign last_w   = count_q - CW'(2);
  assign cm1_w    = count_q - CW'(1);
  assign k_first  = k_q == '0;
  assign k_last   = CW'(k_q) == last_w;
  assign arc_bad  = arc_q < rd_pt.arc;
  assign degen    = (ex_q == '0) && (ey_q == '0);
  assign dot_neg  = dot_q[DOT_W-1];
  assign before_start = dot_neg && !k_first;
  assign past_end = !dot_neg && (dot_q[DOT_W-2:0] > n2_q) && !k_last;
  assign out_free = !out_valid_q || !out_stall_i;
  assign dot_abs  = dot_neg ? -dot_q : dot_q;
  assign cross_abs = cross_q[DOT_W-1] ? -cross_q : cross_q;
  assign ds       = s1_q - s0_q;
  assign term_pos = DOT_W'(mul_p[2*DW-1:0]);
  assign term     = mul_neg ? -term_pos : term_pos;
  assign div_cap  = cap40(div_quo);
  assign s0_ext   = SO_W'(s0_q);
  assign step_ext = SO_W'(div_cap);
  assign mag_ext  = SO_W'(mag_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pfp_pkg::S_IDLE: begin
        if (in_valid_i) begin
          case (pfp_pkg::cmd_e'(command_i))
            pfp_pkg::CMD_APPEND: begin
              if (full) begin
                state_d = pfp_pkg::S_OUT;
              end else if (count_q == '0) begin
                state_d = (arc_pos_i != '0) ? pfp_pkg::S_OUT : pfp_pkg::S_AWR;
              end else begin
                state_d = pfp_pkg::S_ACHK;
              end
            end
            pfp_pkg::CMD_QUERY: state_d = few ? pfp_pkg::S_OUT : pfp_pkg::S_RD0;
            default:            state_d = pfp_pkg::S_OUT;
          endcase
        end
      end
      pfp_pkg::S_ACHK: state_d = arc_bad ? pfp_pkg::S_OUT : pfp_pkg::S_MGO;
      pfp_pkg::S_AWR:  state_d = pfp_pkg::S_OUT;
      pfp_pkg::S_RD0:  state_d = pfp_pkg::S_RD1;
      pfp_pkg::S_RD1:  state_d = pfp_pkg::S_LD;
      pfp_pkg::S_LD:   state_d = pfp_pkg::S_CHK;
      pfp_pkg::S_CHK:  state_d = pfp_pkg::S_MGO;
      pfp_pkg::S_MGO:  state_d = pfp_pkg::S_MWT;
      pfp_pkg::S_MWT: begin
        if (mul_done) begin
          case (mop_q)
            pfp_pkg::MOP_EYEY: state_d = pfp_pkg::S_CLS;
            pfp_pkg::MOP_DDY:  state_d = pfp_pkg::S_QGO;
            pfp_pkg::MOP_PROD: state_d = pfp_pkg::S_DGO;
            default:           state_d = pfp_pkg::S_MGO;
          endcase
        end
      end
      pfp_pkg::S_CLS: begin
        state_d = (before_start || past_end) ? pfp_pkg::S_MGO : pfp_pkg::S_DGO;
      end
      pfp_pkg::S_DGO:  state_d = pfp_pkg::S_DWT;
      pfp_pkg::S_DWT: begin
        if (div_done) begin
          state_d = (dop_q == pfp_pkg::DOP_LAT) ? pfp_pkg::S_MGO : pfp_pkg::S_CMP;
        end
      end
      pfp_pkg::S_QGO:  state_d = pfp_pkg::S_QWT;
      pfp_pkg::S_QWT: begin
        if (sq_done) begin
          state_d = app_q ? pfp_pkg::S_AWR : pfp_pkg::S_CMP;
        end
      end
      pfp_pkg::S_CMP:  state_d = k_last ? pfp_pkg::S_OUT : pfp_pkg::S_RD0;
      pfp_pkg::S_OUT:  state_d = out_free ? pfp_pkg::S_IDLE : pfp_pkg::S_OUT;
      default:         state_d = pfp_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    mem_ctl   = '0;
    raddr     = k_q;
    pt_waddr  = count_q[AW-1:0];
    sl_waddr  = cm1_w[AW-1:0];
    pt_wdata  = '{x: x_q, y: y_q, arc: arc_q};
    mul_start = state_q == pfp_pkg::S_MGO;
    div_start = state_q == pfp_pkg::S_DGO;
    sq_start  = state_q == pfp_pkg::S_QGO;
    case (state_q)
      pfp_pkg::S_IDLE: raddr = cm1_w[AW-1:0];
      pfp_pkg::S_RD1:  raddr = k_q + 1'b1;
      pfp_pkg::S_AWR: begin
        mem_ctl.pt_we = 1'b1;
        mem_ctl.sl_we = count_q != '0;
      end
      default: ;
    endcase
  end

  // multiplier operands: magnitudes, with the product sign kept aside
  always_comb begin
    ma33    = mag33(dx_q);
    mb33    = mag33(ex_q);
    mul_neg = dx_q[DW-1] ^ ex_q[DW-1];
    case (mop_q)
      pfp_pkg::MOP_DYEY: begin
        ma33 = mag33(dy_q); mb33 = mag33(ey_q); mul_neg = dy_q[DW-1] ^ ey_q[DW-1];
      end
      pfp_pkg::MOP_EXDY: begin
        ma33 = mag33(ex_q); mb33 = mag33(dy_q); mul_neg = ex_q[DW-1] ^ dy_q[DW-1];
      end
      pfp_pkg::MOP_EYDX: begin
        ma33 = mag33(ey_q); mb33 = mag33(dx_q); mul_neg = ey_q[DW-1] ^ dx_q[DW-1];
      end
      pfp_pkg::MOP_EXEX: begin
        ma33 = mag33(ex_q); mb33 = mag33(ex_q); mul_neg = 1'b0;
      end
      pfp_pkg::MOP_EYEY: begin
        ma33 = mag33(ey_q); mb33 = mag33(ey_q); mul_neg = 1'b0;
      end
      pfp_pkg::MOP_DDX: begin
        ma33 = mag33(vx_q); mb33 = mag33(vx_q); mul_neg = 1'b0;
      end
      pfp_pkg::MOP_DDY: begin
        ma33 = mag33(vy_q); mb33 = mag33(vy_q); mul_neg = 1'b0;
      end
      default: ;
    endcase
    if (mop_q == pfp_pkg::MOP_PROD) begin
      mul_a = dot_abs[pfp_pkg::MUL_AW-1:0];
      mul_b = pfp_pkg::MUL_BW'(ds);
    end else begin
      mul_a = pfp_pkg::MUL_AW'(ma33);
      mul_b = pfp_pkg::MUL_BW'(mb33);
    end
  end

  assign div_num = (dop_q == pfp_pkg::DOP_LAT) ?
                   pfp_pkg::DIV_NW'(cross_abs[pfp_pkg::MUL_AW-1:0]) : prod_q;
  assign div_den = (dop_q == pfp_pkg::DOP_LAT) ? pfp_pkg::DIV_DW'(sl_q) : n2_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pfp_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire && (pfp_pkg::cmd_e'(command_i) == pfp_pkg::CMD_CLEAR)) begin
        count_q <= '0;
      end else if (state_q == pfp_pkg::S_AWR) begin
        count_q <= count_q + 1'b1;
      end
      if ((state_q == pfp_pkg::S_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      pfp_pkg::S_IDLE: begin
        if (in_fire) begin
          cmd_q    <= pfp_pkg::cmd_e'(command_i);
          x_q      <= x_coord_i;
          y_q      <= y_coord_i;
          arc_q    <= arc_pos_i;
          app_q    <= pfp_pkg::cmd_e'(command_i) == pfp_pkg::CMD_APPEND;
          res_s_q  <= '0;
          res_l_q  <= '0;
          k_q      <= '0;
          have_q   <= 1'b0;
          status_q <= pfp_pkg::STAT_OK;
          case (pfp_pkg::cmd_e'(command_i))
            pfp_pkg::CMD_APPEND: begin
              if (full) begin
                status_q <= pfp_pkg::STAT_FULL;
              end else if ((count_q == '0) && (arc_pos_i != '0)) begin
                status_q <= pfp_pkg::STAT_ARC0;
              end
            end
            pfp_pkg::CMD_QUERY: begin
              if (few) begin
                status_q <= pfp_pkg::STAT_FEW;
              end
            end
            default: ;
          endcase
        end
      end
      pfp_pkg::S_ACHK: begin
        if (arc_bad) begin
          status_q <= pfp_pkg::STAT_DEC;
        end
        vx_q  <= {x_q[31], x_q} - {rd_pt.x[31], rd_pt.x};
        vy_q  <= {y_q[31], y_q} - {rd_pt.y[31], rd_pt.y};
        mop_q <= pfp_pkg::MOP_DDX;
      end
      pfp_pkg::S_RD1: begin
        x0_q <= rd_pt.x;
        y0_q <= rd_pt.y;
        s0_q <= rd_pt.arc;
        sl_q <= rd_sl;
      end
      pfp_pkg::S_LD: begin
        x1_q <= rd_pt.x;
        y1_q <= rd_pt.y;
        s1_q <= rd_pt.arc;
        ex_q <= {rd_pt.x[31], rd_pt.x} - {x0_q[31], x0_q};
        ey_q <= {rd_pt.y[31], rd_pt.y} - {y0_q[31], y0_q};
        dx_q <= {x_q[31], x_q} - {x0_q[31], x0_q};
        dy_q <= {y_q[31], y_q} - {y0_q[31], y0_q};
      end
      pfp_pkg::S_CHK: begin
        // zero-length segment: unsigned distance to its start
        if (degen) begin
          vx_q   <= dx_q;
          vy_q   <= dy_q;
          neg_q  <= 1'b0;
          sseg_q <= s0_ext;
          mop_q  <= pfp_pkg::MOP_DDX;
        end else begin
          mop_q  <= pfp_pkg::MOP_DXEX;
        end
      end
      pfp_pkg::S_MWT: begin
        if (mul_done) begin
          case (mop_q)
            pfp_pkg::MOP_DXEX: begin dot_q <= term; mop_q <= pfp_pkg::MOP_DYEY; end
            pfp_pkg::MOP_DYEY: begin dot_q <= dot_q + term; mop_q <= pfp_pkg::MOP_EXDY; end
            pfp_pkg::MOP_EXDY: begin cross_q <= term; mop_q <= pfp_pkg::MOP_EYDX; end
            pfp_pkg::MOP_EYDX: begin
              cross_q <= cross_q - term;
              mop_q   <= pfp_pkg::MOP_EXEX;
            end
            pfp_pkg::MOP_EXEX: begin
              n2_q  <= mul_p[pfp_pkg::MUL_AW-1:0];
              mop_q <= pfp_pkg::MOP_EYEY;
            end
            pfp_pkg::MOP_EYEY: n2_q <= n2_q + mul_p[pfp_pkg::MUL_AW-1:0];
            pfp_pkg::MOP_DDX: begin
              rad_q <= mul_p[pfp_pkg::MUL_AW-1:0];
              mop_q <= pfp_pkg::MOP_DDY;
            end
            pfp_pkg::MOP_DDY:  rad_q  <= rad_q + mul_p[pfp_pkg::MUL_AW-1:0];
            pfp_pkg::MOP_PROD: begin
              prod_q <= mul_p[pfp_pkg::DIV_NW-1:0];
              dop_q  <= pfp_pkg::DOP_STEP;
            end
            default: ;
          endcase
        end
      end
      pfp_pkg::S_CLS: begin
        neg_q <= cross_q[DOT_W-1];
        mop_q <= pfp_pkg::MOP_DDX;
        dop_q <= pfp_pkg::DOP_LAT;
        if (before_start) begin
          vx_q   <= dx_q;
          vy_q   <= dy_q;
          sseg_q <= s0_ext;
        end else begin
          vx_q   <= {x_q[31], x_q} - {x1_q[31], x1_q};
          vy_q   <= {y_q[31], y_q} - {y1_q[31], y1_q};
          sseg_q <= SO_W'(s1_q);
        end
      end
      pfp_pkg::S_DWT: begin
        if (div_done) begin
          if (dop_q == pfp_pkg::DOP_LAT) begin
            mag_q <= div_cap;
            mop_q <= pfp_pkg::MOP_PROD;
          end else begin
            sseg_q <= dot_neg ? s0_ext - step_ext : s0_ext + step_ext;
          end
        end
      end
      pfp_pkg::S_QWT: begin
        if (sq_done) begin
          mag_q <= MAG_W'(sq_root);
        end
      end
      pfp_pkg::S_CMP: begin
        // strictly smaller wins, so the earlier segment keeps a tie
        if (!have_q || (mag_q < best_q)) begin
          have_q  <= 1'b1;
          best_q  <= mag_q;
          res_s_q <= sseg_q;
          res_l_q <= neg_q ? -mag_ext : mag_ext;
        end
        k_q <= k_q + 1'b1;
      end
      pfp_pkg::S_OUT: begin
        if (out_free) begin
          out_s_q      <= sat32(res_s_q);
          out_l_q      <= sat32(res_l_q);
          out_status_q <= status_q;
        end
      end
      default: ;
    endcase
  end

  pfp_mem #(
    .DEPTH(MAX_POINTS)
  ) u_mem (
    .clk_i      (clk_i),
    .ctl_i      (mem_ctl),
    .pt_waddr_i (pt_waddr),
    .pt_wdata_i (pt_wdata),
    .sl_waddr_i (sl_waddr),
    .sl_wdata_i (sq_root[pfp_pkg::SEGL_W-1:0]),
    .raddr_i    (raddr),
    .pt_rdata_o (rd_pt),
    .sl_rdata_o (rd_sl)
  );

  pfp_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  pfp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  pfp_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (rad_q),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  assign in_stall_o  = state_q != pfp_pkg::S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_s_o     = out_s_q;
  assign out_l_o     = out_l_q;
  assign status_o    = out_status_q;

  // the point count never passes the memory depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_POINTS))
    else $error("point count above depth");

  // the segment walk never passes the last segment index
  a_k_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pfp_pkg::S_CMP) |-> (CW'(k_q) <= last_w))
    else $error("segment index past last segment");

  // words other than queries leave s and l at zero
  a_zero_nonquery: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == pfp_pkg::S_OUT) && (cmd_q != pfp_pkg::CMD_QUERY))
      |-> ((res_s_q == '0) && (res_l_q == '0)))
    else $error("non-query word carries nonzero s or l");

  // the point memory is written only while a point still fits
  a_write_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_ctl.pt_we |-> !full)
    else $error("point write into full path");

endmodule

`default_nettype wire

/* test/tb.sv */
// Self-checking testbench for the polyline Frenet projection block.
`timescale 1ns / 1ps

module tb;

  typedef struct {
    logic [1:0]         cmd;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [30:0]        arc;
  } word_t;

  typedef struct {
    logic signed [31:0] s;
    logic signed [31:0] l;
    logic [2:0]         st;
  } frenet_t;

  localparam int unsigned NPTS = 1024;
  localparam logic [127:0] STEP_CAP = 128'd1 << 40;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] command_i = '0;
  logic signed [31:0] x_coord_i = '0;
  logic signed [31:0] y_coord_i = '0;
  logic [30:0] arc_pos_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] out_s_o;
  logic signed [31:0] out_l_o;
  logic [2:0] status_o;

  polyline_frenet_projection u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .command_i(command_i), .x_coord_i(x_coord_i), .y_coord_i(y_coord_i),
    .arc_pos_i(arc_pos_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .out_s_o(out_s_o), .out_l_o(out_l_o), .status_o(status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Pending words, expected results, idle rates of both sides.
  word_t   word_q[$];
  frenet_t frenet_q[$];
  int      send_idle = 0;
  int      recv_idle = 0;
  int      errors = 0;
  bit      in_took = 1'b0;

  // Predictor copy of the stored path.
  longint      path_x[NPTS];
  longint      path_y[NPTS];
  longint      path_arc[NPTS];
  logic [32:0] seg_len[NPTS];
  int          path_cnt = 0;

  function automatic logic [127:0] isqrt(logic [127:0] v);
    logic [127:0] r, c;
    r = '0;
    for (int b = 35; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  function automatic logic [127:0] hypot(longint dx, longint dy);
    logic signed [127:0] a, b;
    a = dx;
    b = dy;
    return isqrt(a * a + b * b);
  endfunction

  function automatic logic [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // Walk every segment, keep the first one with the smallest |l|.
  function automatic frenet_t project(longint qx, longint qy);
    frenet_t r;
    logic signed [127:0] ex, ey, dx, dy, dot, crs, n2;
    logic [127:0] cm, dm, prod, mag, best, step;
    longint s0, s1, s, bs, bl;
    bit neg, have;
    int last;
    last = path_cnt - 2;
    have = 0;
    best = '0;
    bs = 0;
    bl = 0;
    for (int k = 0; k <= last; k++) begin
      ex = path_x[k+1] - path_x[k];
      ey = path_y[k+1] - path_y[k];
      dx = qx - path_x[k];
      dy = qy - path_y[k];
      s0 = path_arc[k];
      s1 = path_arc[k+1];
      neg = 0;
      if (ex == 0 && ey == 0) begin
        mag = hypot(dx, dy);
        s = s0;
      end else begin
        dot = dx * ex + dy * ey;
        crs = ex * dy - ey * dx;
        n2 = ex * ex + ey * ey;
        neg = crs < 0;
        if (dot < 0 && k > 0) begin
          mag = hypot(dx, dy);
          s = s0;
        end else if (dot > n2 && k < last) begin
          mag = hypot(qx - path_x[k+1], qy - path_y[k+1]);
          s = s1;
        end else begin
          cm = neg ? -crs : crs;
          dm = dot < 0 ? -dot : dot;
          prod = dm * (s1 - s0);
          // a truncated length of zero divides to all ones, hence the cap
          if (seg_len[k] == 0) mag = STEP_CAP;
          else begin
            mag = cm / {95'd0, seg_len[k]};
            if (mag > STEP_CAP) mag = STEP_CAP;
          end
          step = prod / n2;
          if (step > STEP_CAP) step = STEP_CAP;
          s = dot < 0 ? s0 - longint'(step) : s0 + longint'(step);
        end
      end
      if (!have || mag < best) begin
        have = 1;
        best = mag;
        bs = s;
        bl = neg ? -longint'(mag) : longint'(mag);
      end
    end
    r.s = sat32(bs);
    r.l = sat32(bl);
    r.st = pfp_pkg::STAT_OK;
    return r;
  endfunction

  function automatic frenet_t predict_word(word_t w);
    frenet_t r;
    logic [127:0] d;
    r.s = '0;
    r.l = '0;
    r.st = pfp_pkg::STAT_OK;
    case (w.cmd)
      pfp_pkg::CMD_CLEAR: path_cnt = 0;
      pfp_pkg::CMD_APPEND: begin
        if (path_cnt >= NPTS) r.st = pfp_pkg::STAT_FULL;
        else if (path_cnt == 0 && w.arc != 0) r.st = pfp_pkg::STAT_ARC0;
        else if (path_cnt > 0 && longint'(w.arc) < path_arc[path_cnt-1])
          r.st = pfp_pkg::STAT_DEC;
        else begin
          if (path_cnt > 0) begin
            d = hypot(longint'(w.x) - path_x[path_cnt-1], longint'(w.y) - path_y[path_cnt-1]);
            seg_len[path_cnt-1] = d[32:0];
          end
          path_x[path_cnt] = w.x;
          path_y[path_cnt] = w.y;
          path_arc[path_cnt] = w.arc;
          path_cnt++;
        end
      end
      pfp_pkg::CMD_QUERY: begin
        if (path_cnt < 2) r.st = pfp_pkg::STAT_FEW;
        else r = project(w.x, w.y);
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %0h, expected %0h", field, got, want);
    errors++;
  endtask

  // Monitor: check the result word first, then predict the word taken in.
  always @(posedge clk_i) begin
    frenet_t e;
    word_t w;
    if (out_valid_o && !out_stall_i) begin
      if (frenet_q.size() == 0) begin
        $display("result word with no expectation pending");
        errors++;
      end else begin
        e = frenet_q.pop_front();
        if (out_s_o !== e.s) report("out_s", out_s_o, e.s);
        if (out_l_o !== e.l) report("out_l", out_l_o, e.l);
        if (status_o !== e.st) report("status", {29'd0, status_o}, {29'd0, e.st});
      end
    end
    in_took = in_valid_i && !in_stall_o;
    if (in_took) begin
      w.cmd = command_i;
      w.x = x_coord_i;
      w.y = y_coord_i;
      w.arc = arc_pos_i;
      frenet_q.insert(frenet_q.size(), predict_word(w));
    end
  end

  // Driver: hold a word until taken, idle at random between words.
  always @(negedge clk_i) begin
    word_t w;
    if (rst_ni) begin
      out_stall_i <= ($urandom_range(99) < recv_idle);
      if (!in_valid_i || in_took) begin
        if (word_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          w = word_q.pop_front();
          command_i <= w.cmd;
          x_coord_i <= w.x;
          y_coord_i <= w.y;
          arc_pos_i <= w.arc;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic push(logic [1:0] cmd, logic [31:0] x, logic [31:0] y, logic [30:0] arc);
    word_t w;
    w.cmd = cmd;
    w.x = x;
    w.y = y;
    w.arc = arc;
    word_q.insert(word_q.size(), w);
  endtask

  function automatic logic [31:0] pick_coord(bit wide);
    int v;
    case ($urandom_range(9))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: begin
        v = wide ? $urandom_range(0, 2000000000) - 1000000000
                 : $urandom_range(0, 40000) - 20000;
        return v;
      end
    endcase
  endfunction

  // One random path: clear, a few appends with now and then a bad-arc append or an idle word, then queries.
  task automatic add_path(ref int words);
    int npts, nq;
    bit wide;
    logic [31:0] x, y;
    logic [30:0] arc, jump;
    npts = $urandom_range(9) == 0 ? $urandom_range(0, 1) : $urandom_range(2, 6);
    nq = $urandom_range(2, 4);
    wide = $urandom_range(3) == 0;
    push(pfp_pkg::CMD_CLEAR, $urandom, $urandom, $urandom);
    arc = '0;
    x = pick_coord(wide);
    y = pick_coord(wide);
    for (int i = 0; i < npts; i++) begin
      if (i > 0 && $urandom_range(5) != 0) begin
        x = pick_coord(wide);
        y = pick_coord(wide);
      end
      jump = wide ? $urandom_range(0, 32'h1fffffff) : $urandom_range(0, 6000);
      if (i > 0) arc = (31'h7fffffff - arc < jump) ? 31'h7fffffff : arc + jump;
      case ($urandom_range(19))
        0: begin
          push(pfp_pkg::CMD_APPEND, x, y, arc == 0 ? 31'd1 + $urandom_range(0, 99) : arc - 1);
          words++;
        end
        1: begin
          push(pfp_pkg::CMD_NONE, $urandom, $urandom, $urandom);
          words++;
        end
        default: ;
      endcase
      push(pfp_pkg::CMD_APPEND, x, y, arc);
    end
    for (int i = 0; i < nq; i++)
      push(pfp_pkg::CMD_QUERY, pick_coord(wide), pick_coord(wide), $urandom);
    words += npts + nq + 1;
  endtask

  task automatic drain();
    while (word_q.size() > 0 || in_valid_i || frenet_q.size() > 0) @(posedge clk_i);
  endtask

  initial begin
    int words;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty and short path, bad arcs, zero-length segment, clamps.
    push(pfp_pkg::CMD_QUERY, 32'd5, 32'd5, '0);
    push(pfp_pkg::CMD_APPEND, 32'd0, 32'd0, 31'd7);
    push(pfp_pkg::CMD_APPEND, 32'd0, 32'd0, 31'd0);
    push(pfp_pkg::CMD_QUERY, 32'd100, 32'd100, '0);
    push(pfp_pkg::CMD_APPEND, 32'd1024, 32'd0, 31'd1000);
    push(pfp_pkg::CMD_APPEND, 32'd2048, 32'd0, 31'd500);
    push(pfp_pkg::CMD_APPEND, 32'd1024, 32'd0, 31'd1000);
    push(pfp_pkg::CMD_APPEND, 32'd2048, 32'd1024, 31'd2000);
    push(pfp_pkg::CMD_APPEND, 32'd4096, 32'd1024, 31'd4000);
    push(pfp_pkg::CMD_QUERY, -32'sd500, 32'd300, '0);
    push(pfp_pkg::CMD_QUERY, 32'd1024, 32'd0, '0);
    push(pfp_pkg::CMD_QUERY, 32'd800, -32'sd400, '0);
    push(pfp_pkg::CMD_QUERY, 32'd3000, 32'd2000, '0);
    push(pfp_pkg::CMD_QUERY, 32'd9000, -32'sd700, '0);
    push(pfp_pkg::CMD_NONE, 32'hffffffff, 32'hffffffff, 31'h7fffffff);
    push(pfp_pkg::CMD_QUERY, 32'h80000000, 32'h7fffffff, 31'h7fffffff);
    push(pfp_pkg::CMD_CLEAR, '0, '0, '0);
    push(pfp_pkg::CMD_APPEND, 32'h80000000, 32'h80000000, 31'd0);
    push(pfp_pkg::CMD_APPEND, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff);
    push(pfp_pkg::CMD_APPEND, 32'h80000000, 32'h7fffffff, 31'h7fffffff);
    push(pfp_pkg::CMD_QUERY, 32'h7fffffff, 32'h80000000, '0);
    push(pfp_pkg::CMD_QUERY, 32'h80000000, 32'h80000000, '0);
    push(pfp_pkg::CMD_QUERY, 32'd0, 32'd0, '0);
    push(pfp_pkg::CMD_CLEAR, '0, '0, '0);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = ph == 0 ? 28 : ph == 1 ? 76 : 0;
      recv_idle = ph == 0 ? 76 : ph == 1 ? 28 : 0;
      words = 0;
      while (words < 185) add_path(words);
      drain();
    end

    repeat (50) @(posedge clk_i);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #200ms;
    $display("Verification failed");
    $finish;
  end

endmodule
